>>> rtl/core/positional_list_engine_top_defines.svh
// Assertion macros for the positional list engine top level.
// Depends on clk and rst_n in the scope where the macros are used.
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, reset-qualified
`define PL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset-qualified
`define PL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pl_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies.
package pl_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int CNT_W_DEF = 5;
    localparam int POS_W     = 8;
    localparam int DATA_W    = 32;
    localparam int ENTRY_W   = 2 * DATA_W;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_DUMP   = 2'd3
    } pl_cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_NONPOS = 3'd1,
        ST_RANGE  = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_FULL   = 3'd4
    } pl_status_e;

    // what a cell loads on the next edge
    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_LOAD = 3'd1,
        CELL_PREV = 3'd2,
        CELL_NEXT = 3'd3,
        CELL_HEAD = 3'd4
    } pl_cell_op_e;

endpackage

>>> rtl/core/pl_cmd_if.sv
// Command channel: valid/ready handshake carrying one command word.
// Depends on pl_pkg.
interface pl_cmd_if import pl_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] product_code;
    logic [DATA_W-1:0]        price_cents;

    modport source (output valid, cmd, position, product_code, price_cents, input ready);
    modport sink   (input valid, cmd, position, product_code, price_cents, output ready);

endinterface

>>> rtl/core/pl_res_if.sv
// Result channel: valid/ready handshake carrying one result word.
// Depends on pl_pkg; CntW sizes the position and count fields.
interface pl_res_if import pl_pkg::*; #(parameter int CntW = CNT_W_DEF) ();

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [CntW-1:0]          entry_position;
    logic signed [DATA_W-1:0] entry_code;
    logic [DATA_W-1:0]        entry_price;
    logic [CntW-1:0]          entry_count;
    logic                     is_empty;
    logic                     last_of_run;

    modport source (output valid, status, entry_position, entry_code, entry_price,
                    entry_count, is_empty, last_of_run, input ready);
    modport sink   (input valid, status, entry_position, entry_code, entry_price,
                    entry_count, is_empty, last_of_run, output ready);

endinterface

>>> rtl/core/pl_cell.sv
// One storage cell of the list chain: holds one entry, takes from a neighbour, the head or the load input.
// Depends on pl_pkg.
module pl_cell import pl_pkg::*;
(
    input  logic               clk,
    input  pl_cell_op_e        op,
    input  logic [ENTRY_W-1:0] prev,
    input  logic [ENTRY_W-1:0] next,
    input  logic [ENTRY_W-1:0] head,
    input  logic [ENTRY_W-1:0] load,
    output logic [ENTRY_W-1:0] q
);

    logic [ENTRY_W-1:0] q_reg;
    logic [ENTRY_W-1:0] q_next;

    always_comb
    begin
        case (op)
            CELL_LOAD: q_next = load;
            CELL_PREV: q_next = prev;
            CELL_NEXT: q_next = next;
            CELL_HEAD: q_next = head;
            default:   q_next = q_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

>>> rtl/core/positional_list_engine_top.sv
// Every result word is registered; the first word for a command appears the cycle after the command is taken.
// Clear, insert and delete each give one word; back to back at one per cycle while the result word is taken.
// Dump of n entries gives n words (one word if empty); the chain rotates one place per cycle while
// the result register is free, so no command is taken until the last dump word has been registered.
// Reset (rst_n low, async): count zero, no word pending, FSM idle; cell contents not cleared.
// Depends on pl_pkg, pl_cmd_if, pl_res_if, pl_cell and positional_list_engine_top_defines.svh.
`include "positional_list_engine_top_defines.svh"

module positional_list_engine_top import pl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    pl_cmd_if.sink     req,
    pl_res_if.source   rsp
);

    localparam int CntW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t              state_reg, state_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic [CntW-1:0]     dpos_reg, dpos_next;    // position of the next dump word

    logic                rsp_valid_reg, rsp_valid_next;
    pl_status_e          rsp_status_reg, rsp_status_next;
    logic [CntW-1:0]     rsp_pos_reg, rsp_pos_next;
    logic [ENTRY_W-1:0]  rsp_data_reg, rsp_data_next;
    logic [CntW-1:0]     rsp_count_reg, rsp_count_next;
    logic                rsp_last_reg, rsp_last_next;

    // chain of cells; cell 0 is the head of the list
    logic [ENTRY_W-1:0]  cell_q [DEPTH];
    pl_cell_op_e         cell_op [DEPTH];

    logic                out_free;
    logic                accept;
    pl_cmd_e             cmd;
    logic [POS_W-1:0]    pos_u;
    logic [POS_W-1:0]    cnt_ext;
    logic [POS_W-1:0]    sel;       // 0-based target cell
    logic [POS_W-1:0]    tail;      // last occupied cell, used while rotating
    logic                nonpos;
    logic                ins_range;
    logic                del_range;
    logic                is_full;
    logic                is_zero;
    logic                ins_ok;
    logic                del_ok;
    logic                dump_step;
    logic                dump_more;
    logic [ENTRY_W-1:0]  new_entry;

    // ---------------------------------------------------------------
    // Handshake: output register frees as the word is taken
    // ---------------------------------------------------------------
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    // ---------------------------------------------------------------
    // Command decode and range checks
    // ---------------------------------------------------------------
    assign cmd       = pl_cmd_e'(req.cmd);
    assign pos_u     = req.position;
    assign cnt_ext   = POS_W'(count_reg);
    assign sel       = pos_u - POS_W'(1);
    assign tail      = cnt_ext - POS_W'(1);
    assign nonpos    = (pos_u == '0) || pos_u[POS_W-1];
    assign ins_range = pos_u > (cnt_ext + POS_W'(1));
    assign del_range = pos_u > cnt_ext;
    assign is_full   = count_reg == CntW'(DEPTH);
    assign is_zero   = count_reg == '0;
    assign new_entry = {req.product_code, req.price_cents};

    assign ins_ok = accept && (cmd == CMD_INSERT) && !nonpos && !ins_range && !is_full;
    assign del_ok = accept && (cmd == CMD_DELETE) && !nonpos && !is_zero && !del_range;

    // a dump word leaves each cycle the head is read: first on accept, then in S_DUMP
    assign dump_step = (accept && (cmd == CMD_DUMP) && !is_zero)
                     || ((state_reg == S_DUMP) && out_free);

    // ---------------------------------------------------------------
    // Per-cell control and the chain itself
    //   insert: target loads, cells above shift up one
    //   delete: target and above take from the right
    //   dump:   occupied cells rotate left, head wraps to the tail
    // ---------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [POS_W-1:0] Idx = POS_W'(i);
        logic [ENTRY_W-1:0] prev_d;
        logic [ENTRY_W-1:0] next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = cell_q[i];
        end
        else
        begin : g_mid
            assign prev_d = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_d = cell_q[i];
        end
        else
        begin : g_inner
            assign next_d = cell_q[i+1];
        end

        always_comb
        begin
            cell_op[i] = CELL_HOLD;
            if (ins_ok)
            begin
                if (Idx == sel)
                    cell_op[i] = CELL_LOAD;
                else if (Idx > sel)
                    cell_op[i] = CELL_PREV;
            end
            else if (del_ok)
            begin
                if (Idx >= sel)
                    cell_op[i] = CELL_NEXT;
            end
            else if (dump_step)
            begin
                if (Idx == tail)
                    cell_op[i] = CELL_HEAD;
                else if (Idx < tail)
                    cell_op[i] = CELL_NEXT;
            end
        end

        pl_cell u_cell (
            .clk  (clk),
            .op   (cell_op[i]),
            .prev (prev_d),
            .next (next_d),
            .head (cell_q[0]),
            .load (new_entry),
            .q    (cell_q[i])
        );
    end

    // ---------------------------------------------------------------
    // Next-state: count, dump position, result word
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        dpos_next       = dpos_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_pos_next    = rsp_pos_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_last_next   = rsp_last_reg;
        dump_more       = 1'b0;

        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_pos_next   = '0;
            rsp_data_next  = '0;
            rsp_last_next  = 1'b1;
            case (cmd)
                CMD_CLEAR:
                begin
                    rsp_status_next = ST_OK;
                    count_next      = '0;
                end
                CMD_INSERT:
                begin
                    if (nonpos)
                        rsp_status_next = ST_NONPOS;
                    else if (ins_range)
                        rsp_status_next = ST_RANGE;
                    else if (is_full)
                        rsp_status_next = ST_FULL;
                    else
                    begin
                        rsp_status_next = ST_OK;
                        count_next      = count_reg + CntW'(1);
                    end
                end
                CMD_DELETE:
                begin
                    if (nonpos)
                        rsp_status_next = ST_NONPOS;
                    else if (is_zero)
                        rsp_status_next = ST_EMPTY;
                    else if (del_range)
                        rsp_status_next = ST_RANGE;
                    else
                    begin
                        rsp_status_next = ST_OK;
                        count_next      = count_reg - CntW'(1);
                    end
                end
                CMD_DUMP:
                begin
                    if (is_zero)
                        rsp_status_next = ST_EMPTY;
                    else
                    begin
                        rsp_status_next = ST_OK;
                        rsp_pos_next    = CntW'(1);
                        rsp_data_next   = cell_q[0];
                        rsp_last_next   = count_reg == CntW'(1);
                        dump_more       = count_reg != CntW'(1);
                    end
                end
                default:
                begin
                    rsp_status_next = ST_OK;
                end
            endcase
            rsp_count_next = count_next;
            if (dump_more)
            begin
                state_next = S_DUMP;
                dpos_next  = CntW'(2);
            end
        end
        else if ((state_reg == S_DUMP) && out_free)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = ST_OK;
            rsp_pos_next    = dpos_reg;
            rsp_data_next   = cell_q[0];
            rsp_count_next  = count_reg;
            rsp_last_next   = dpos_reg == count_reg;
            dpos_next       = dpos_reg + CntW'(1);
            if (dpos_reg == count_reg)
                state_next = S_IDLE;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            dpos_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_pos_reg    <= '0;
            rsp_data_reg   <= '0;
            rsp_count_reg  <= '0;
            rsp_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            dpos_reg       <= dpos_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_pos_reg    <= rsp_pos_next;
            rsp_data_reg   <= rsp_data_next;
            rsp_count_reg  <= rsp_count_next;
            rsp_last_reg   <= rsp_last_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.entry_position = rsp_pos_reg;
    assign rsp.entry_code     = rsp_data_reg[ENTRY_W-1:DATA_W];
    assign rsp.entry_price    = rsp_data_reg[DATA_W-1:0];
    assign rsp.entry_count    = rsp_count_reg;
    assign rsp.is_empty       = rsp_count_reg == '0;
    assign rsp.last_of_run    = rsp_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `PL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CntW'(DEPTH), "entry count above depth")
    `PL_ASSERT_NOW(a_dump_blocks, state_reg == S_DUMP, !req.ready, "command taken mid-dump")
    `PL_ASSERT_NEXT(a_insert_count, ins_ok, count_reg == $past(count_reg) + CntW'(1), "insert count")
    `PL_ASSERT_NOW(a_dump_pos, state_reg == S_DUMP, (dpos_reg >= CntW'(2)) && (dpos_reg <= count_reg), "dump position out of run")

endmodule
